/* rtl/core/swmd_pkg.sv */
// Package for the stack with middle delete: sizes, field types, status and
// operation codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package swmd_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MIN_MIDDLE  = 3;

    localparam int ADDR_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int DEPTH_W  = 5;
    localparam int M_DATA_W = ((POS_W + DEPTH_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [DEPTH_W-1:0]  depth_t;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_EMPTY       = 3'd1;
    localparam status_t ST_UNDER_THREE = 3'd2;
    localparam status_t ST_NOT_FOUND   = 3'd3;
    localparam status_t ST_IS_TOP      = 3'd4;
    localparam status_t ST_IS_BOTTOM   = 3'd5;
    localparam status_t ST_FULL        = 3'd6;

    typedef struct packed {
        logic load;    // input transaction taken this cycle
        logic srch;    // search step
        logic shft;    // shift step
        logic finish;  // hand result to the output register
    } cmd_t;

    typedef struct packed {
        logic quick;       // item resolved at load
        logic hit;         // match found
        logic hit_mid;     // match is neither top nor bottom
        logic miss_end;    // bottom checked, no match
        logic shift_last;  // last gap-closing write
        logic out_free;    // output register can take a result
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/swmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/swmd_ctrl.sv */
// Controller state machine for the stack with middle delete.
// Uses swmd_pkg for the command and status structs.
`default_nettype none

module swmd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire swmd_pkg::stat_t st,
    output      swmd_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.quick ? S_FINISH : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.srch = 1'b1;
                if (st.hit_mid)
                begin
                    state_next = S_SHIFT;
                end
                else if (st.hit || st.miss_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.shft = 1'b1;
                if (st.shift_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swmd_dp.sv */
// Datapath for the stack with middle delete: entry RAM, depth counter,
// search and shift pointers, result and output registers.
// Uses swmd_pkg and swmd_ram.
`default_nettype none

module swmd_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            op,
    input  wire swmd_pkg::value_t                value,
    input  wire swmd_pkg::cmd_t                  cmd,
    output      swmd_pkg::stat_t                 st,
    output      logic                            out_valid,
    input  wire logic                            out_ready,
    output      swmd_pkg::status_t               out_status,
    output      logic [swmd_pkg::M_DATA_W-1:0]   out_data
);

    swmd_pkg::cnt_t    count_reg;
    swmd_pkg::cnt_t    count_next;
    logic              iss_vld_reg;
    logic              iss_vld_next;
    logic              chk_vld_reg;
    logic              chk_vld_next;
    logic              wr_vld_reg;
    logic              wr_vld_next;
    logic              m_valid_reg;
    logic              m_valid_next;

    swmd_pkg::value_t  key_reg;
    swmd_pkg::addr_t   ptr_reg;
    swmd_pkg::addr_t   ptr_next;
    swmd_pkg::addr_t   chk_reg;
    swmd_pkg::addr_t   wr_ptr_reg;
    swmd_pkg::addr_t   wr_ptr_next;
    swmd_pkg::status_t res_status_reg;
    swmd_pkg::status_t res_status_next;
    swmd_pkg::pos_t    res_pos_reg;
    swmd_pkg::pos_t    res_pos_next;
    swmd_pkg::status_t m_status_reg;
    swmd_pkg::pos_t    m_pos_reg;
    swmd_pkg::depth_t  m_depth_reg;

    logic              ram_we;
    swmd_pkg::addr_t   ram_waddr;
    swmd_pkg::value_t  ram_wdata;
    swmd_pkg::value_t  ram_rdata;

    logic              full;
    logic              push_ok;
    logic              eq;
    logic              out_load;
    swmd_pkg::cnt_t    chk_cnt;
    swmd_pkg::cnt_t    top_cnt;

    swmd_ram #(
        .WIDTH (swmd_pkg::VALUE_W),
        .DEPTH (swmd_pkg::STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign full     = (count_reg == swmd_pkg::cnt_t'(swmd_pkg::STACK_DEPTH));
    assign push_ok  = cmd.load && (op == swmd_pkg::OP_PUSH) && !full;
    assign eq       = (ram_rdata == key_reg);
    assign chk_cnt  = swmd_pkg::cnt_t'(chk_reg);
    assign top_cnt  = count_reg - swmd_pkg::cnt_t'(1);
    assign out_load = cmd.finish && st.out_free;

    assign st.quick      = (op == swmd_pkg::OP_PUSH)
                           || (count_reg < swmd_pkg::cnt_t'(swmd_pkg::MIN_MIDDLE));
    assign st.hit        = chk_vld_reg && eq;
    assign st.miss_end   = chk_vld_reg && !eq && (chk_reg == '0);
    assign st.hit_mid    = st.hit && (chk_reg != '0) && (chk_cnt != top_cnt);
    assign st.shift_last = wr_vld_reg
                           && (swmd_pkg::cnt_t'(wr_ptr_reg) == count_reg - swmd_pkg::cnt_t'(2));
    assign st.out_free   = !m_valid_reg || out_ready;

    // push writes on top; shift moves the entry above down into the gap
    assign ram_we    = push_ok || (cmd.shft && wr_vld_reg);
    assign ram_waddr = cmd.load ? swmd_pkg::addr_t'(count_reg) : wr_ptr_reg;
    assign ram_wdata = cmd.load ? value : ram_rdata;

    always_comb
    begin
        count_next   = count_reg;
        iss_vld_next = iss_vld_reg;
        chk_vld_next = 1'b0;
        wr_vld_next  = 1'b0;
        ptr_next     = ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next = m_valid_reg && !out_ready;

        if (cmd.load)
        begin
            iss_vld_next = 1'b1;
            ptr_next     = swmd_pkg::addr_t'(top_cnt);
            res_pos_next = '0;
            if (op == swmd_pkg::OP_PUSH)
            begin
                res_status_next = full ? swmd_pkg::ST_FULL : swmd_pkg::ST_OK;
                if (!full)
                begin
                    count_next = count_reg + swmd_pkg::cnt_t'(1);
                end
            end
            else
            begin
                res_status_next = (count_reg == '0) ? swmd_pkg::ST_EMPTY
                                                    : swmd_pkg::ST_UNDER_THREE;
            end
        end

        if (cmd.srch)
        begin
            chk_vld_next = iss_vld_reg && !st.hit;
            if (st.hit_mid)
            begin
                // restart reads one above the match for the shift
                iss_vld_next = 1'b1;
                ptr_next     = chk_reg + swmd_pkg::addr_t'(1);
                wr_ptr_next  = chk_reg;
            end
            else if (iss_vld_reg)
            begin
                if (ptr_reg == '0)
                begin
                    iss_vld_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg - swmd_pkg::addr_t'(1);
                end
            end
            if (st.hit)
            begin
                res_pos_next = swmd_pkg::pos_t'(top_cnt - chk_cnt);
                if (st.hit_mid)
                begin
                    res_status_next = swmd_pkg::ST_OK;
                end
                else if (chk_cnt == top_cnt)
                begin
                    res_status_next = swmd_pkg::ST_IS_TOP;
                end
                else
                begin
                    res_status_next = swmd_pkg::ST_IS_BOTTOM;
                end
            end
            else if (st.miss_end)
            begin
                res_status_next = swmd_pkg::ST_NOT_FOUND;
                res_pos_next    = '0;
            end
        end

        if (cmd.shft)
        begin
            wr_vld_next = iss_vld_reg;
            if (iss_vld_reg)
            begin
                if (swmd_pkg::cnt_t'(ptr_reg) == top_cnt)
                begin
                    iss_vld_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg + swmd_pkg::addr_t'(1);
                end
            end
            if (wr_vld_reg)
            begin
                wr_ptr_next = wr_ptr_reg + swmd_pkg::addr_t'(1);
            end
            if (st.shift_last)
            begin
                count_next = count_reg - swmd_pkg::cnt_t'(1);
            end
        end

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            iss_vld_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            iss_vld_reg <= iss_vld_next;
            chk_vld_reg <= chk_vld_next;
            wr_vld_reg  <= wr_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= value;
        end
        if (cmd.srch)
        begin
            chk_reg <= ptr_reg;
        end
        ptr_reg        <= ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        if (out_load)
        begin
            m_status_reg <= res_status_reg;
            m_pos_reg    <= res_pos_reg;
            m_depth_reg  <= swmd_pkg::depth_t'(count_reg);
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_data   = swmd_pkg::M_DATA_W'({m_depth_reg, m_pos_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swmd_pkg::cnt_t'(swmd_pkg::STACK_DEPTH))
        else $error("entry count above stack depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> count_reg == swmd_pkg::cnt_t'($past(count_reg) + swmd_pkg::cnt_t'(1)))
        else $error("accepted push did not grow the stack");

    a_shift_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shft && wr_vld_reg) |-> (swmd_pkg::cnt_t'(wr_ptr_reg) < top_cnt))
        else $error("shift write at or above top entry");

    a_shift_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.srch && st.hit_mid) |=> (iss_vld_reg && !wr_vld_reg
                                      && ptr_reg == $past(chk_reg) + swmd_pkg::addr_t'(1)))
        else $error("shift did not start above the match");

endmodule

`default_nettype wire

/* rtl/core/stack_with_middle_delete.sv */
// Top level of the bounded stack with delete-by-value of a middle entry.
// Uses swmd_pkg, swmd_ctrl and swmd_dp.
//
//  port group   dir  tdata                      tuser
//  s_*          in   [31:0] value               [0] operation (0 push, 1 delete)
//  m_*          out  [3:0] position, [8:4] depth [2:0] status
//
// Push and refused deletes go from acceptance to the finish step, which loads m_*; s_tready returns as m_* is loaded.
// A delete reads one entry per cycle from the top through the single RAM read port:
// a match or a miss at the bottom entry ends the search, and a middle match then runs gap-closing
// shift steps that move each entry above it down by one before the finish step loads m_*.
// The next item is accepted while a result waits in m_*; its finish step holds until m_tready.
// Reset empties the stack; entry RAM contents are not cleared.
`default_nettype none

module stack_with_middle_delete (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [31:0]                   s_tdata,   // [31:0] value
    input  wire logic [0:0]                    s_tuser,   // [0] operation
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [swmd_pkg::M_DATA_W-1:0] m_tdata,   // [3:0] position, [8:4] depth
    output      logic [2:0]                    m_tuser    // [2:0] status
);

    swmd_pkg::cmd_t  cmd;
    swmd_pkg::stat_t st;

    swmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    swmd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (s_tuser[0]),
        .value      (s_tdata),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire
